>>> rtl/nnsbw_pkg.sv
// Package for the nearest-neighbor scaled blit walker.
// Holds the shared widths, configuration indexes, FSM state and controller/datapath structs.
`default_nettype none
package nnsbw_pkg;

    localparam int MAX_DIM_DEF = 8192;

    localparam int DIM_W   = 14;
    localparam int RECT_W  = 16;
    localparam int COORD_W = 13;
    localparam int POS_W   = 18;
    localparam int PROD_W  = RECT_W + DIM_W;
    localparam int QUO_W   = DIM_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 56;

    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT     = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]  surface_width;
        logic [DIM_W-1:0]  surface_height;
        logic [RECT_W-1:0] rect_left;
        logic [RECT_W-1:0] rect_top;
        logic [RECT_W-1:0] rect_width;
        logic [RECT_W-1:0] rect_height;
        logic [DIM_W-1:0]  src_width;
        logic [DIM_W-1:0]  src_height;
    } nnsbw_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_OUT
    } nnsbw_state_t;

    typedef struct packed {
        logic accept;
        logic calc_en;
        logic mul_en;
        logic div_start;
        logic out_load;
    } nnsbw_cmd_t;

    typedef struct packed {
        logic calc_valid;
        logic div_done;
        logic out_free;
    } nnsbw_status_t;

endpackage
`default_nettype wire

>>> rtl/nnsbw_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses nnsbw_pkg widths; quotient must fit in QUO_W bits.
`default_nettype none
module nnsbw_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [nnsbw_pkg::PROD_W-1:0] dividend,
    input  wire logic [nnsbw_pkg::RECT_W-1:0] divisor,
    output logic      [nnsbw_pkg::QUO_W-1:0]  quotient,
    output logic                            done
);
    import nnsbw_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [RECT_W-1:0] rem_reg;
    logic [QUO_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [RECT_W:0]   trial;
    logic              fits;
    logic [RECT_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[QUO_W-1]};
        fits  = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[PROD_W-1:QUO_W];
            dvd_reg <= dividend[QUO_W-1:0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[RECT_W-1:0] : trial[RECT_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

>>> rtl/nnsbw_ctrl.sv
// Sequencing FSM of the blit walker: request intake, step, multiply, divide, result load.
// Depends on nnsbw_pkg for the state enum and command/status structs.
`default_nettype none
module nnsbw_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire nnsbw_pkg::nnsbw_status_t status,
    output nnsbw_pkg::nnsbw_cmd_t         cmd
);
    import nnsbw_pkg::*;

    nnsbw_state_t state_reg;
    nnsbw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc_en = 1'b1;
                state_next  = status.calc_valid ? ST_MUL : ST_OUT;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/nnsbw_dp.sv
// Datapath of the blit walker: clip, walk position, local offsets, products,
// two shared-step dividers and the output register. Depends on nnsbw_pkg and nnsbw_div.
`default_nettype none
module nnsbw_dp #(
    parameter int MAX_DIM = nnsbw_pkg::MAX_DIM_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire nnsbw_pkg::nnsbw_cfg_t        cfg,
    input  wire logic                         restart,
    input  wire nnsbw_pkg::nnsbw_cmd_t        cmd,
    output nnsbw_pkg::nnsbw_status_t          status,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [nnsbw_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import nnsbw_pkg::*;

    localparam logic [16:0] MAX_DIM_V = 17'(MAX_DIM);

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = ({3'b000, v} > MAX_DIM_V) ? MAX_DIM_V[DIM_W-1:0] : v;
        return r;
    endfunction

    logic [DIM_W-1:0] sw, sh, iw, ih;
    logic signed [POS_W-1:0] org_x, org_y, left_c, top_c, right_u, bottom_u;
    logic signed [POS_W-1:0] right_c, bottom_c, sw_s, sh_s;
    logic signed [POS_W-1:0] nx, ny, loc_x, loc_y;
    logic empty, in_range, calc_valid, is_last;

    logic                restart_reg;
    logic                walking_reg;
    logic [COORD_W-1:0]  cur_x_reg, cur_y_reg;
    logic                res_valid_reg, res_last_reg;
    logic [COORD_W-1:0]  pos_x_reg, pos_y_reg;
    logic [RECT_W-1:0]   local_x_reg, local_y_reg;
    logic [PROD_W-1:0]   prod_x_reg, prod_y_reg;
    logic [QUO_W-1:0]    quo_x, quo_y;
    logic                done_x, done_y;
    logic [QUO_W-1:0]    src_x_c, src_y_c;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_user_reg, out_last_reg;

    always_comb
    begin
        sw = sat_dim(cfg.surface_width);
        sh = sat_dim(cfg.surface_height);
        iw = sat_dim(cfg.src_width);
        ih = sat_dim(cfg.src_height);
        sw_s = $signed({4'b0000, sw});
        sh_s = $signed({4'b0000, sh});
        org_x = $signed({{2{cfg.rect_left[RECT_W-1]}}, cfg.rect_left});
        org_y = $signed({{2{cfg.rect_top[RECT_W-1]}}, cfg.rect_top});
        left_c = (org_x < 0) ? '0 : org_x;
        top_c  = (org_y < 0) ? '0 : org_y;
        right_u  = org_x + $signed({2'b00, cfg.rect_width});
        bottom_u = org_y + $signed({2'b00, cfg.rect_height});
        right_c  = (right_u > sw_s) ? sw_s : right_u;
        bottom_c = (bottom_u > sh_s) ? sh_s : bottom_u;
        empty = (cfg.rect_width == '0) || (cfg.rect_height == '0) ||
                (iw == '0) || (ih == '0) ||
                (left_c >= right_c) || (top_c >= bottom_c);

        if (restart_reg)
        begin
            nx = left_c;
            ny = top_c;
        end
        else
        begin
            nx = $signed({5'b00000, cur_x_reg}) + 18'sd1;
            ny = $signed({5'b00000, cur_y_reg});
            if (nx >= right_c)
            begin
                nx = left_c;
                ny = ny + 18'sd1;
            end
        end
        in_range = (nx >= left_c) && (nx < right_c) && (ny >= top_c) && (ny < bottom_c);
        calc_valid = !empty && (restart_reg || (walking_reg && in_range));
        is_last = (nx == right_c - 18'sd1) && (ny == bottom_c - 18'sd1);
        loc_x = nx - org_x;
        loc_y = ny - org_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walking_reg <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
        end
        else if (cmd.calc_en)
        begin
            walking_reg <= calc_valid && !is_last;
            if (calc_valid)
            begin
                cur_x_reg <= nx[COORD_W-1:0];
                cur_y_reg <= ny[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            restart_reg <= restart;
        end
        if (cmd.calc_en)
        begin
            res_valid_reg <= calc_valid;
            res_last_reg  <= calc_valid && is_last;
            pos_x_reg     <= nx[COORD_W-1:0];
            pos_y_reg     <= ny[COORD_W-1:0];
            local_x_reg   <= loc_x[RECT_W-1:0];
            local_y_reg   <= loc_y[RECT_W-1:0];
        end
        if (cmd.mul_en)
        begin
            prod_x_reg <= PROD_W'(local_x_reg * iw);
            prod_y_reg <= PROD_W'(local_y_reg * ih);
        end
    end

    nnsbw_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_x_reg),
        .divisor  (cfg.rect_width),
        .quotient (quo_x),
        .done     (done_x)
    );

    nnsbw_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_y_reg),
        .divisor  (cfg.rect_height),
        .quotient (quo_y),
        .done     (done_y)
    );

    always_comb
    begin
        src_x_c = (quo_x >= iw) ? iw - 1'b1 : quo_x;
        src_y_c = (quo_y >= ih) ? ih - 1'b1 : quo_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_user_reg <= res_valid_reg;
            out_last_reg <= res_valid_reg && res_last_reg;
            if (res_valid_reg)
            begin
                out_data_reg <= {4'h0, src_y_c[COORD_W-1:0], src_x_c[COORD_W-1:0],
                                 pos_y_reg, pos_x_reg};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign status.calc_valid = calc_valid;
    assign status.div_done   = done_x && done_y;
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

>>> rtl/nearest_neighbor_scaled_blit_walker.sv
// Top level of the nearest-neighbor scaled blit walker: configuration registers,
// controller and datapath. Depends on nnsbw_pkg, nnsbw_ctrl, nnsbw_dp.
//
// Each request (restart = 1 starts at the clipped top-left, 0 advances one pixel) yields
// one result: destination x/y and nearest source x/y = floor(local * image / rect), with a
// valid flag on tuser and tlast on the final pixel of the clipped rectangle. A request that
// produces a pixel goes through a step/clip state, a multiply state, a divider start state,
// a wait state in which two parallel radix-2 dividers retire one quotient bit each until
// both finish, and an output load state that waits for a free output register. A request
// with no pixel (idle walker, empty region, walk past the end) goes from step/clip straight
// to output load. The next request is accepted in the cycle after the result is loaded,
// even while that result still waits in the output register. The user must write the
// configuration through cfg_we/cfg_index/cfg_data only while the block is idle; the block
// does not enforce this. The clip is reevaluated on every request.
`default_nettype none
module nearest_neighbor_scaled_blit_walker #(
    parameter int MAX_DIM = nnsbw_pkg::MAX_DIM_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [nnsbw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nnsbw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [nnsbw_pkg::S_DATA_W-1:0]    s_tdata,  // [0] restart, [7:1] zero
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [nnsbw_pkg::M_DATA_W-1:0]         m_tdata,  // out_x, out_y, src_x, src_y
    output logic                                   m_tuser,  // valid_res
    output logic                                   m_tlast
);
    import nnsbw_pkg::*;

    nnsbw_cfg_t    cfg_reg;
    nnsbw_cmd_t    cmd;
    nnsbw_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SURFACE_WIDTH:  cfg_reg.surface_width  <= cfg_data[DIM_W-1:0];
                REG_SURFACE_HEIGHT: cfg_reg.surface_height <= cfg_data[DIM_W-1:0];
                REG_RECT_LEFT:      cfg_reg.rect_left      <= cfg_data;
                REG_RECT_TOP:       cfg_reg.rect_top       <= cfg_data;
                REG_RECT_WIDTH:     cfg_reg.rect_width     <= cfg_data;
                REG_RECT_HEIGHT:    cfg_reg.rect_height    <= cfg_data;
                REG_SRC_WIDTH:      cfg_reg.src_width      <= cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT:     cfg_reg.src_height     <= cfg_data[DIM_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    nnsbw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nnsbw_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .restart  (s_tdata[0]),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0 && !m_tlast))
        else $error("invalid result carries nonzero payload");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last flagged on invalid result");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in work");

endmodule
`default_nettype wire
